[hdl/mqs_pkg.sv]
`timescale 1ns / 1ps

package mqs_pkg;

   typedef logic [2:0]        slot_type;
   typedef logic [1:0]        phase_type;
   typedef logic signed [1:0] count_type;
   typedef logic [10:0]       button_type;

   localparam int REPORT_COUNT = 5;

   localparam slot_type SLOT_TONE_THREE = 3'd0;
   localparam slot_type SLOT_JOG        = 3'd1;
   localparam slot_type SLOT_VOLUME     = 3'd2;
   localparam slot_type SLOT_BUTTONS    = 3'd3;
   localparam slot_type SLOT_TONE_ONE   = 3'd4;
   localparam slot_type SLOT_UNUSED     = 3'd5;
   localparam slot_type SLOT_TONE_TWO   = 3'd6;
   localparam slot_type SLOT_REPORT     = 3'd7;

   localparam logic [2:0] ENC_VOLUME     = 3'd0;
   localparam logic [2:0] ENC_JOG        = 3'd1;
   localparam logic [2:0] ENC_TONE_ONE   = 3'd2;
   localparam logic [2:0] ENC_TONE_TWO   = 3'd3;
   localparam logic [2:0] ENC_TONE_THREE = 3'd4;

   localparam int BTN_TONE3  = 0;
   localparam int BTN_JOG    = 1;
   localparam int BTN_OUT    = 2;
   localparam int BTN_FN1    = 3;
   localparam int BTN_FN2    = 4;
   localparam int BTN_FN3    = 5;
   localparam int BTN_TONE1  = 6;
   localparam int BTN_TONE2  = 7;
   localparam int BTN_HOTCUE = 8;
   localparam int BTN_PLAY   = 9;
   localparam int BTN_NAV    = 10;

   localparam count_type STEP_ZERO = 2'sb00;
   localparam count_type STEP_UP   = 2'sb01;
   localparam count_type STEP_DOWN = 2'sb11;

   // indexed by {previous phase, new phase}
   localparam count_type STEP_TABLE [16] = '{
      STEP_ZERO, STEP_DOWN, STEP_UP,   STEP_ZERO,
      STEP_UP,   STEP_ZERO, STEP_ZERO, STEP_DOWN,
      STEP_DOWN, STEP_ZERO, STEP_ZERO, STEP_UP,
      STEP_ZERO, STEP_UP,   STEP_DOWN, STEP_ZERO
   };

   // encoder slots: 0, 1, 2, 4, 6
   localparam logic [7:0] SLOT_HAS_ENC = 8'b0101_0111;

   localparam logic [2:0] SLOT_ENC_INDEX [8] = '{
      ENC_TONE_THREE, ENC_JOG, ENC_VOLUME, ENC_VOLUME,
      ENC_TONE_ONE, ENC_VOLUME, ENC_TONE_TWO, ENC_VOLUME
   };

endpackage

[hdl/mqs_if.sv]
`timescale 1ns / 1ps

interface mqs_req_if;
   import mqs_pkg::*;

   logic     valid;
   logic     ready;
   slot_type slot;
   logic     pin_a;
   logic     pin_b;
   logic     pin_sw;

   modport source (output valid, output slot, output pin_a, output pin_b, output pin_sw,
                   input ready);
   modport sink   (input valid, input slot, input pin_a, input pin_b, input pin_sw,
                   output ready);
endinterface

interface mqs_rsp_if;
   import mqs_pkg::*;

   logic       valid;
   logic       ready;
   count_type  volume_count;
   count_type  jog_count;
   count_type  tone_one_count;
   count_type  tone_two_count;
   count_type  tone_three_count;
   button_type button_mask;

   modport source (output valid, output volume_count, output jog_count,
                   output tone_one_count, output tone_two_count,
                   output tone_three_count, output button_mask, input ready);
   modport sink   (input valid, input volume_count, input jog_count,
                   input tone_one_count, input tone_two_count,
                   input tone_three_count, input button_mask, output ready);
endinterface

[hdl/multiplexed_quadrature_scanner.sv]
`timescale 1ns / 1ps

// Scanner for five quadrature encoders and eleven buttons that share the A, B and
// switch lines through an 8-way multiplexer. Each request is one sampled slot; a new
// request is taken every cycle as long as the one-entry response register is empty
// or being drained that cycle. Only a slot 7 request produces a response, in the
// cycle after the request is accepted, carrying the
// saturated (-1..+1) step count of each encoder since the previous report and the
// latched button mask; the counts are then cleared. Encoders at or above
// ENCODER_COUNT are not tracked and report zero.
module multiplexed_quadrature_scanner
   import mqs_pkg::*;
#(
   parameter int ENCODER_COUNT = 5
) (
   input logic        clock,
   input logic        reset,
   mqs_req_if.sink    req_bus,
   mqs_rsp_if.source  rsp_bus
);

   logic       req_fire;
   logic       report_hit;
   phase_type  new_phase;
   button_type button_ff;
   button_type button_in;
   phase_type  phase_ff [ENCODER_COUNT];
   count_type  acc_ff   [ENCODER_COUNT];
   count_type  rpt_count [REPORT_COUNT];

   logic       rsp_valid_ff;
   count_type  rsp_count_ff [REPORT_COUNT];
   button_type rsp_mask_ff;

   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign report_hit    = req_fire && (req_bus.slot == SLOT_REPORT);
   assign new_phase     = {req_bus.pin_a, req_bus.pin_b};

   genvar e;
   generate
      for (e = 0; e < ENCODER_COUNT; e++) begin : g_enc
         logic              hit;
         count_type         step;
         logic signed [2:0] sum;
         count_type         sat;

         assign hit  = SLOT_HAS_ENC[req_bus.slot] &&
                       (SLOT_ENC_INDEX[req_bus.slot] == 3'(e));
         assign step = STEP_TABLE[{phase_ff[e], new_phase}];
         assign sum  = {acc_ff[e][1], acc_ff[e]} + {step[1], step};

         always_comb begin
            if (sum > 3'sd1) begin
               sat = STEP_UP;
            end else if (sum < -3'sd1) begin
               sat = STEP_DOWN;
            end else begin
               sat = sum[1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff[e] <= '0;
               acc_ff[e]   <= STEP_ZERO;
            end else if (req_fire && hit) begin
               phase_ff[e] <= new_phase;
               acc_ff[e]   <= sat;
            end else if (report_hit) begin
               acc_ff[e]   <= STEP_ZERO;
            end
         end
      end

      for (e = 0; e < REPORT_COUNT; e++) begin : g_rpt
         if (e < ENCODER_COUNT) begin : g_on
            assign rpt_count[e] = acc_ff[e];
         end else begin : g_off
            assign rpt_count[e] = STEP_ZERO;
         end
      end
   endgenerate

   always_comb begin
      button_in = button_ff;
      case (req_bus.slot)
         SLOT_TONE_THREE: button_in[BTN_TONE3] = ~req_bus.pin_sw;
         SLOT_JOG:        button_in[BTN_JOG]   = ~req_bus.pin_sw;
         SLOT_VOLUME:     button_in[BTN_OUT]   = ~req_bus.pin_sw;
         SLOT_BUTTONS: begin
            button_in[BTN_FN1] = ~req_bus.pin_a;
            button_in[BTN_FN2] = ~req_bus.pin_b;
            button_in[BTN_FN3] = ~req_bus.pin_sw;
         end
         SLOT_TONE_ONE:   button_in[BTN_TONE1] = ~req_bus.pin_sw;
         SLOT_TONE_TWO:   button_in[BTN_TONE2] = ~req_bus.pin_sw;
         SLOT_REPORT: begin
            button_in[BTN_HOTCUE] = ~req_bus.pin_a;
            button_in[BTN_PLAY]   = ~req_bus.pin_b;
            button_in[BTN_NAV]    = ~req_bus.pin_sw;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_ff <= '0;
      end else if (req_fire) begin
         button_ff <= button_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (report_hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (report_hit) begin
         rsp_count_ff <= rpt_count;
         rsp_mask_ff  <= button_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.volume_count     = rsp_count_ff[ENC_VOLUME];
   assign rsp_bus.jog_count        = rsp_count_ff[ENC_JOG];
   assign rsp_bus.tone_one_count   = rsp_count_ff[ENC_TONE_ONE];
   assign rsp_bus.tone_two_count   = rsp_count_ff[ENC_TONE_TWO];
   assign rsp_bus.tone_three_count = rsp_count_ff[ENC_TONE_THREE];
   assign rsp_bus.button_mask      = rsp_mask_ff;

endmodule

[hdl/mqs_checker.sv]
`timescale 1ns / 1ps

module mqs_checker
   import mqs_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input slot_type req_slot,
   input logic     rsp_valid,
   input logic     rsp_ready
);

   logic req_fire;
   logic report_fire;

   assign req_fire    = req_valid & req_ready;
   assign report_fire = req_fire && (req_slot == SLOT_REPORT);

   assert property (@(posedge clock) disable iff (reset)
      report_fire |=> rsp_valid)
      else $error("report request did not produce a response");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(report_fire))
      else $error("response appeared without a report request");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_slot != SLOT_REPORT) && !rsp_valid) |=> !rsp_valid)
      else $error("non-report request produced a response");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind multiplexed_quadrature_scanner mqs_checker u_mqs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_slot  (req_bus.slot),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import mqs_pkg::*;

   localparam int TRACKED_ENCODERS = 5;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int RANDOM_SCANS     = 1900;
   localparam int STEP_BY_TRANSITION [16] = '{
      0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0
   };

   typedef struct {
      count_type  volume;
      count_type  jog;
      count_type  tone_one;
      count_type  tone_two;
      count_type  tone_three;
      button_type mask;
   } report_type;

   logic clock;
   logic reset;

   mqs_req_if req_bus ();
   mqs_rsp_if rsp_bus ();

   multiplexed_quadrature_scanner #(
      .ENCODER_COUNT(TRACKED_ENCODERS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   phase_type  enc_phase [REPORT_COUNT];
   count_type  enc_steps [REPORT_COUNT];
   button_type pressed;
   report_type pending_reports [$];
   int         failure_count = 0;
   int         quiet_cycles  = 0;
   bit         pacing_on     = 1'b1;

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= 10) $display("%s", msg);
   endtask

   function automatic int encoder_of(input slot_type slot);
      case (slot)
         SLOT_VOLUME:     return ENC_VOLUME;
         SLOT_JOG:        return ENC_JOG;
         SLOT_TONE_ONE:   return ENC_TONE_ONE;
         SLOT_TONE_TWO:   return ENC_TONE_TWO;
         SLOT_TONE_THREE: return ENC_TONE_THREE;
         default:         return -1;
      endcase
   endfunction

   function automatic int switch_button_of(input slot_type slot);
      case (slot)
         SLOT_TONE_THREE: return BTN_TONE3;
         SLOT_JOG:        return BTN_JOG;
         SLOT_VOLUME:     return BTN_OUT;
         SLOT_BUTTONS:    return BTN_FN3;
         SLOT_TONE_ONE:   return BTN_TONE1;
         SLOT_TONE_TWO:   return BTN_TONE2;
         SLOT_REPORT:     return BTN_NAV;
         default:         return -1;
      endcase
   endfunction

   function automatic phase_type next_phase(input phase_type p, input int dir);
      if (dir > 0) begin
         case (p)
            2'd0: return 2'd2;
            2'd2: return 2'd3;
            2'd3: return 2'd1;
            default: return 2'd0;
         endcase
      end else if (dir < 0) begin
         case (p)
            2'd0: return 2'd1;
            2'd1: return 2'd3;
            2'd3: return 2'd2;
            default: return 2'd0;
         endcase
      end
      return p;
   endfunction

   function automatic void scan_slot(input slot_type slot, input logic a, input logic b,
                                     input logic sw);
      int         enc;
      int         btn;
      int         sum;
      phase_type  phase;
      report_type rep;
      if (slot == SLOT_UNUSED) return;
      enc = encoder_of(slot);
      if (enc >= 0 && enc < TRACKED_ENCODERS) begin
         phase = {a, b};
         sum = int'(enc_steps[enc]) + STEP_BY_TRANSITION[{enc_phase[enc], phase}];
         if (sum > 1) sum = 1;
         if (sum < -1) sum = -1;
         enc_steps[enc] = count_type'(sum);
         enc_phase[enc] = phase;
      end
      btn = switch_button_of(slot);
      if (btn >= 0) pressed[btn] = !sw;
      if (slot == SLOT_BUTTONS) begin
         pressed[BTN_FN1] = !a;
         pressed[BTN_FN2] = !b;
      end
      if (slot != SLOT_REPORT) return;
      pressed[BTN_HOTCUE] = !a;
      pressed[BTN_PLAY]   = !b;
      rep.volume     = enc_steps[ENC_VOLUME];
      rep.jog        = enc_steps[ENC_JOG];
      rep.tone_one   = enc_steps[ENC_TONE_ONE];
      rep.tone_two   = enc_steps[ENC_TONE_TWO];
      rep.tone_three = enc_steps[ENC_TONE_THREE];
      rep.mask       = pressed;
      pending_reports.push_back(rep);
      for (int i = 0; i < REPORT_COUNT; i++) enc_steps[i] = STEP_ZERO;
   endfunction

   task automatic send_scan(input slot_type slot, input logic a, input logic b,
                            input logic sw);
      int gap;
      gap = pacing_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.slot   <= slot;
      req_bus.pin_a  <= a;
      req_bus.pin_b  <= b;
      req_bus.pin_sw <= sw;
      @(posedge clock iff (req_bus.valid && req_bus.ready));
      scan_slot(slot, a, b, sw);
   endtask

   task automatic step_encoder(input slot_type slot, input int dir, input logic sw);
      phase_type p;
      p = next_phase(enc_phase[encoder_of(slot)], dir);
      send_scan(slot, p[1], p[0], sw);
   endtask

   task automatic compare_field(input string name, input integer want, input integer got);
      if (want !== got)
         note_failure($sformatf("mismatch %s: expected %0d, actual %0d", name, want, got));
   endtask

   // response side: stall, then take one report and check it
   initial begin
      int         stall;
      report_type want;
      forever begin
         stall = pacing_on ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock iff (rsp_bus.valid && rsp_bus.ready));
         if (pending_reports.size() == 0) begin
            note_failure("report with no scan pending");
         end else begin
            want = pending_reports.pop_front();
            compare_field("volume_count", want.volume, rsp_bus.volume_count);
            compare_field("jog_count", want.jog, rsp_bus.jog_count);
            compare_field("tone_one_count", want.tone_one, rsp_bus.tone_one_count);
            compare_field("tone_two_count", want.tone_two, rsp_bus.tone_two_count);
            compare_field("tone_three_count", want.tone_three, rsp_bus.tone_three_count);
            compare_field("button_mask", want.mask, rsp_bus.button_mask);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_first_report_after_reset();
      send_scan(SLOT_REPORT, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_encoder_directions();
      step_encoder(SLOT_TONE_THREE, 1, 1'b1);
      step_encoder(SLOT_JOG, -1, 1'b1);
      step_encoder(SLOT_VOLUME, 1, 1'b1);
      step_encoder(SLOT_TONE_ONE, -1, 1'b1);
      step_encoder(SLOT_TONE_TWO, 1, 1'b1);
      send_scan(SLOT_REPORT, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_saturation();
      repeat (3) step_encoder(SLOT_VOLUME, 1, 1'b1);
      repeat (3) step_encoder(SLOT_JOG, -1, 1'b1);
      send_scan(SLOT_REPORT, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_buttons();
      send_scan(SLOT_BUTTONS, 1'b0, 1'b0, 1'b0);
      send_scan(SLOT_REPORT, 1'b0, 1'b0, 1'b0);
      send_scan(SLOT_BUTTONS, 1'b1, 1'b1, 1'b1);
      send_scan(SLOT_REPORT, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_unused_slot();
      send_scan(SLOT_UNUSED, 1'b0, 1'b0, 1'b0);
      send_scan(SLOT_UNUSED, 1'b1, 1'b1, 1'b1);
      send_scan(SLOT_REPORT, 1'b0, 1'b1, 1'b0);
   endtask

   task automatic test_random_scans();
      slot_type enc_slots [5];
      int       sweep_dir [5];
      int       pick;
      int       which;
      int       scans;
      enc_slots = '{SLOT_VOLUME, SLOT_JOG, SLOT_TONE_ONE, SLOT_TONE_TWO, SLOT_TONE_THREE};
      sweep_dir = '{1, -1, 1, -1, 0};
      scans = 0;
      while (scans < RANDOM_SCANS) begin
         if (scans % 150 == 0) pacing_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_scan(SLOT_REPORT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 16) begin
            send_scan(SLOT_BUTTONS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else if (pick < 20) begin
            send_scan(SLOT_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            continue;
         end else if (pick < 88) begin
            which = $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0)
               sweep_dir[which] = int'($urandom_range(0, 2)) - 1;
            step_encoder(enc_slots[which], sweep_dir[which], 1'($urandom_range(0, 1)));
         end else begin
            // noise: any slot, any pin levels, skipped phases included
            send_scan(slot_type'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         scans++;
      end
      pacing_on = 1'b1;
      send_scan(SLOT_REPORT, 1'b1, 1'b1, 1'b1);
   endtask

   initial begin
      for (int i = 0; i < REPORT_COUNT; i++) begin
         enc_phase[i] = 2'd0;
         enc_steps[i] = STEP_ZERO;
      end
      pressed = '0;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.slot   <= SLOT_UNUSED;
      req_bus.pin_a  <= 1'b1;
      req_bus.pin_b  <= 1'b1;
      req_bus.pin_sw <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_first_report_after_reset();
      test_encoder_directions();
      test_saturation();
      test_buttons();
      test_unused_slot();
      test_random_scans();

      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failure_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
